// ===== rtl/pstad_pkg.sv =====
// ----------------------------------------------------------------------------
// pstad_pkg
// Shared types and constants of the per-source traffic anomaly detector.
// ----------------------------------------------------------------------------
package pstad_pkg;

    localparam int DEF_TABLE_ENTRIES     = 256;
    localparam int DEF_MAX_TRACKED_PORTS = 32;
    localparam int NUM_SENS              = 4;
    localparam int SEEN_CNT_W            = 7;   // holds up to 127 tracked ports

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_THR    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SENS_LIMIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAFFIC_LIM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SENS_PORT_A = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SENS_PORT_B = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SENS_PORT_C = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SENS_PORT_D = 3'd6;

    localparam logic [4:0]  RST_SCAN_THR    = 5'd25;
    localparam logic [15:0] RST_SENS_LIMIT  = 16'd100;
    localparam logic [31:0] RST_TRAFFIC_LIM = 32'd5000;
    localparam logic [15:0] RST_SENS_PORT_A = 16'd22;
    localparam logic [15:0] RST_SENS_PORT_B = 16'd23;
    localparam logic [15:0] RST_SENS_PORT_C = 16'd445;
    localparam logic [15:0] RST_SENS_PORT_D = 16'd3389;

    localparam logic [2:0] KIND_PORT_SCAN  = 3'd0;
    localparam logic [2:0] KIND_SENSITIVE  = 3'd1;
    localparam logic [2:0] KIND_TRAFFIC    = 3'd2;
    localparam logic [2:0] KIND_TABLE_FULL = 3'd3;
    localparam logic [2:0] KIND_QUERY_HIT  = 3'd4;
    localparam logic [2:0] KIND_QUERY_MISS = 3'd5;

    localparam logic CMD_PACKET = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    // alert mask bit positions, in emission order
    localparam int ALERT_SCAN    = 0;
    localparam int ALERT_TRAFFIC = 5;
    localparam int ALERT_W       = 6;

    typedef struct packed {
        logic [31:0]           packets;
        logic [47:0]           bytes;
        logic [31:0]           tcp;
        logic [31:0]           udp;
        logic [31:0]           susp;
        logic [SEEN_CNT_W-1:0] seen_cnt;
    } rec_t;

    typedef logic [NUM_SENS-1:0][15:0] sens_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_PREP,
        ST_PSCAN,
        ST_COMMIT,
        ST_EMIT
    } state_t;

endpackage

// ===== rtl/per_source_traffic_anomaly_detector_core.sv =====
// ----------------------------------------------------------------------------
// per_source_traffic_anomaly_detector_core
// Per-source packet accounting with port-scan, sensitive-port and
// excess-traffic alerts, kept in on-chip record memories.
// ----------------------------------------------------------------------------
// Usage:
//   A command is taken when start is high and busy is low: cmd selects
//   packet accounting or a counter query for source_address. busy stays
//   high until the last result of that command has been put out.
//   Each result is shown for one cycle with result_valid high; last_result
//   marks the final one. A quiet packet gives no result at all.
//   Lookup: the source lookup walks the filled part of the address memory,
//   one entry per cycle; a TCP packet then walks the up to MAX_TRACKED_PORTS
//   ports stored for its source, and the alerts are put out one per cycle.
//   Lookup dominates as the table fills.
//   Configuration writes (cfg_write, cfg_index, cfg_data) take effect at the
//   clock edge and are meant for idle periods.
//   Reset empties the table (fill count to zero) and reloads the register
//   defaults; no clearing pass is needed. The receiver cannot stall.
// ----------------------------------------------------------------------------
module per_source_traffic_anomaly_detector_core
    import pstad_pkg::*;
#(
    parameter int TABLE_ENTRIES     = DEF_TABLE_ENTRIES,
    parameter int MAX_TRACKED_PORTS = DEF_MAX_TRACKED_PORTS
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  start,
    output logic                  busy,
    input  logic                  cmd,
    input  logic [31:0]           source_address,
    input  logic                  is_tcp,
    input  logic                  is_udp,
    input  logic [15:0]           destination_port,
    input  logic [15:0]           frame_length,

    output logic                  result_valid,
    output logic [2:0]            alert_kind,
    output logic [31:0]           alert_address,
    output logic [15:0]           alert_port,
    output logic [31:0]           packet_total,
    output logic [47:0]           byte_total,
    output logic [31:0]           tcp_total,
    output logic [31:0]           udp_total,
    output logic [31:0]           suspicious_total,
    output logic                  last_result
);

    localparam int IDXW   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int FW     = $clog2(TABLE_ENTRIES + 1);
    localparam int PDEPTH = TABLE_ENTRIES * MAX_TRACKED_PORTS;
    localparam int PW     = $clog2(PDEPTH);
    localparam int PCW    = $clog2(MAX_TRACKED_PORTS + 1);

    // configuration
    logic [4:0]  scan_thr_reg;
    logic [15:0] sens_limit_reg;
    logic [31:0] traffic_lim_reg;
    sens_t       sens_port_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_thr_reg     <= RST_SCAN_THR;
            sens_limit_reg   <= RST_SENS_LIMIT;
            traffic_lim_reg  <= RST_TRAFFIC_LIM;
            sens_port_reg[0] <= RST_SENS_PORT_A;
            sens_port_reg[1] <= RST_SENS_PORT_B;
            sens_port_reg[2] <= RST_SENS_PORT_C;
            sens_port_reg[3] <= RST_SENS_PORT_D;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_SCAN_THR:    scan_thr_reg     <= cfg_data[4:0];
                CFG_SENS_LIMIT:  sens_limit_reg   <= cfg_data[15:0];
                CFG_TRAFFIC_LIM: traffic_lim_reg  <= cfg_data;
                CFG_SENS_PORT_A: sens_port_reg[0] <= cfg_data[15:0];
                CFG_SENS_PORT_B: sens_port_reg[1] <= cfg_data[15:0];
                CFG_SENS_PORT_C: sens_port_reg[2] <= cfg_data[15:0];
                CFG_SENS_PORT_D: sens_port_reg[3] <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // memories
    logic [31:0] addr_mem [TABLE_ENTRIES];
    rec_t        rec_mem  [TABLE_ENTRIES];
    sens_t       sens_mem [TABLE_ENTRIES];
    logic [15:0] port_mem [PDEPTH];

    logic            addr_rd_en, addr_wr_en;
    logic [IDXW-1:0] addr_rd_idx;
    logic [31:0]     addr_rd_q;
    logic            rec_rd_en, rec_wr_en;
    logic [IDXW-1:0] rec_rd_idx;
    rec_t            rec_wr_data, rec_rd_q;
    sens_t           sens_wr_data, sens_rd_q;
    logic            port_rd_en, port_wr_en;
    logic [PW-1:0]   port_rd_idx, port_wr_idx;
    logic [15:0]     port_rd_q;

    // command and lookup state
    state_t          state_reg, state_next;
    logic            cmd_reg;
    logic [31:0]     key_reg;
    logic            tcp_reg, udp_reg;
    logic [15:0]     dport_reg, flen_reg;
    logic [FW-1:0]   fill_reg, fill_next;
    logic [FW-1:0]   scan_idx_reg, scan_idx_next;
    logic [IDXW-1:0] last_idx_reg, last_idx_next;
    logic            pend_reg, pend_next;
    logic [IDXW-1:0] ent_reg, ent_next;
    rec_t            rec_reg, rec_next;
    sens_t           sens_reg, sens_next;
    logic [PW-1:0]   pbase_reg, pbase_next;
    logic [PCW-1:0]  pidx_reg, pidx_next;
    logic            found_reg, found_next;
    logic [ALERT_W-1:0] mask_reg, mask_next;

    // result registers
    logic        res_valid_reg, res_valid_next;
    logic [2:0]  kind_reg, kind_next;
    logic [31:0] raddr_reg, raddr_next;
    logic [15:0] rport_reg, rport_next;
    rec_t        rtot_reg, rtot_next;
    logic        rlast_reg, rlast_next;

    always_ff @(posedge clk)
    begin
        if (addr_wr_en)
        begin
            addr_mem[ent_next] <= key_reg;
        end
        if (addr_rd_en)
        begin
            addr_rd_q <= addr_mem[addr_rd_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_wr_en)
        begin
            rec_mem[ent_reg]  <= rec_wr_data;
            sens_mem[ent_reg] <= sens_wr_data;
        end
        if (rec_rd_en)
        begin
            rec_rd_q  <= rec_mem[rec_rd_idx];
            sens_rd_q <= sens_mem[rec_rd_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (port_wr_en)
        begin
            port_mem[port_wr_idx] <= dport_reg;
        end
        if (port_rd_en)
        begin
            port_rd_q <= port_mem[port_rd_idx];
        end
    end

    // lookup / port walk compare results
    logic           addr_hit, port_hit, table_full;
    logic [PCW-1:0] cur_cnt;

    assign addr_hit   = pend_reg && (addr_rd_q == key_reg);
    assign port_hit   = pend_reg && (port_rd_q == dport_reg);
    assign table_full = (fill_reg == FW'(TABLE_ENTRIES));
    assign cur_cnt    = PCW'(rec_reg.seen_cnt);

    // commit arithmetic
    logic [31:0]         pk_new, tcp_new, udp_new;
    logic [48:0]         byte_sum;
    logic [47:0]         byte_new;
    logic [PCW-1:0]      cnt_new;
    sens_t               sens_new;
    logic [ALERT_W-1:0]  alert_mask;
    logic [2:0]          alert_cnt;
    logic [32:0]         susp_sum;
    logic [31:0]         susp_new;
    rec_t                rec_upd;

    always_comb
    begin
        pk_new   = (&rec_reg.packets) ? rec_reg.packets : rec_reg.packets + 32'd1;
        byte_sum = {1'b0, rec_reg.bytes} + 49'(flen_reg);
        byte_new = byte_sum[48] ? {48{1'b1}} : byte_sum[47:0];
        tcp_new  = (tcp_reg && !(&rec_reg.tcp)) ? rec_reg.tcp + 32'd1 : rec_reg.tcp;
        udp_new  = (udp_reg && !(&rec_reg.udp)) ? rec_reg.udp + 32'd1 : rec_reg.udp;
        cnt_new  = cur_cnt;
        if (tcp_reg && !found_reg && (cur_cnt < PCW'(MAX_TRACKED_PORTS)))
        begin
            cnt_new = cur_cnt + PCW'(1);
        end
        alert_mask = '0;
        for (int i = 0; i < NUM_SENS; i++)
        begin
            sens_new[i] = sens_reg[i];
            if (tcp_reg && (dport_reg == sens_port_reg[i]) && !(&sens_reg[i]))
            begin
                sens_new[i] = sens_reg[i] + 16'd1;
            end
            alert_mask[1 + i] = tcp_reg && (sens_new[i] > sens_limit_reg);
        end
        alert_mask[ALERT_SCAN]    = tcp_reg && (8'(cnt_new) > 8'(scan_thr_reg));
        alert_mask[ALERT_TRAFFIC] = (pk_new > traffic_lim_reg);
        alert_cnt = 3'($countones(alert_mask[4:0]));
        susp_sum  = {1'b0, rec_reg.susp} + 33'(alert_cnt);
        susp_new  = susp_sum[32] ? {32{1'b1}} : susp_sum[31:0];
        rec_upd.packets  = pk_new;
        rec_upd.bytes    = byte_new;
        rec_upd.tcp      = tcp_new;
        rec_upd.udp      = udp_new;
        rec_upd.susp     = susp_new;
        rec_upd.seen_cnt = SEEN_CNT_W'(cnt_new);
    end

    // lowest pending alert
    logic [2:0]         emit_bit;
    logic [ALERT_W-1:0] mask_rest;

    always_comb
    begin
        emit_bit = 3'd0;
        for (int i = ALERT_W - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                emit_bit = 3'(i);
            end
        end
        mask_rest           = mask_reg;
        mask_rest[emit_bit] = 1'b0;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (addr_hit)
                begin
                    state_next = ST_READ;
                end
                else if (scan_idx_reg >= fill_reg)
                begin
                    state_next = (cmd_reg == CMD_QUERY || table_full) ? ST_IDLE : ST_PREP;
                end
            end
            ST_READ:
            begin
                state_next = (cmd_reg == CMD_QUERY) ? ST_IDLE : ST_PREP;
            end
            ST_PREP:
            begin
                state_next = tcp_reg ? ST_PSCAN : ST_COMMIT;
            end
            ST_PSCAN:
            begin
                if (port_hit || !(pidx_reg < cur_cnt))
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                state_next = (alert_mask == '0) ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT:
            begin
                if (mask_rest == '0)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and result outputs
    always_comb
    begin
        fill_next     = fill_reg;
        scan_idx_next = scan_idx_reg;
        last_idx_next = last_idx_reg;
        pend_next     = pend_reg;
        ent_next      = ent_reg;
        rec_next      = rec_reg;
        sens_next     = sens_reg;
        pbase_next    = pbase_reg;
        pidx_next     = pidx_reg;
        found_next    = found_reg;
        mask_next     = mask_reg;

        addr_rd_en   = 1'b0;
        addr_rd_idx  = scan_idx_reg[IDXW-1:0];
        addr_wr_en   = 1'b0;
        rec_rd_en    = 1'b0;
        rec_rd_idx   = last_idx_reg;
        rec_wr_en    = 1'b0;
        rec_wr_data  = rec_upd;
        sens_wr_data = sens_new;
        port_rd_en   = 1'b0;
        port_rd_idx  = pbase_reg + PW'(pidx_reg);
        port_wr_en   = 1'b0;
        port_wr_idx  = pbase_reg + PW'(cur_cnt);

        res_valid_next = 1'b0;
        kind_next      = kind_reg;
        raddr_next     = key_reg;
        rport_next     = '0;
        rtot_next      = '0;
        rlast_next     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                scan_idx_next = '0;
                pend_next     = 1'b0;
            end
            ST_SCAN:
            begin
                if (addr_hit)
                begin
                    ent_next  = last_idx_reg;
                    rec_rd_en = 1'b1;
                end
                else if (scan_idx_reg < fill_reg)
                begin
                    addr_rd_en    = 1'b1;
                    last_idx_next = scan_idx_reg[IDXW-1:0];
                    scan_idx_next = scan_idx_reg + FW'(1);
                    pend_next     = 1'b1;
                end
                else if (cmd_reg == CMD_QUERY)
                begin
                    res_valid_next = 1'b1;
                    kind_next      = KIND_QUERY_MISS;
                    rlast_next     = 1'b1;
                end
                else if (table_full)
                begin
                    res_valid_next = 1'b1;
                    kind_next      = KIND_TABLE_FULL;
                    rlast_next     = 1'b1;
                end
                else
                begin
                    // new source takes the next free entry
                    ent_next   = fill_reg[IDXW-1:0];
                    addr_wr_en = 1'b1;
                    fill_next  = fill_reg + FW'(1);
                    rec_next   = '0;
                    sens_next  = '0;
                end
            end
            ST_READ:
            begin
                if (cmd_reg == CMD_QUERY)
                begin
                    res_valid_next = 1'b1;
                    kind_next      = KIND_QUERY_HIT;
                    rtot_next      = rec_rd_q;
                    rlast_next     = 1'b1;
                end
                else
                begin
                    rec_next  = rec_rd_q;
                    sens_next = sens_rd_q;
                end
            end
            ST_PREP:
            begin
                pbase_next = PW'(ent_reg * MAX_TRACKED_PORTS);
                pidx_next  = '0;
                pend_next  = 1'b0;
                found_next = 1'b0;
            end
            ST_PSCAN:
            begin
                if (port_hit)
                begin
                    found_next = 1'b1;
                end
                else if (pidx_reg < cur_cnt)
                begin
                    port_rd_en = 1'b1;
                    pidx_next  = pidx_reg + PCW'(1);
                    pend_next  = 1'b1;
                end
            end
            ST_COMMIT:
            begin
                rec_wr_en  = 1'b1;
                port_wr_en = tcp_reg && !found_reg
                             && (cur_cnt < PCW'(MAX_TRACKED_PORTS));
                mask_next  = alert_mask;
            end
            ST_EMIT:
            begin
                res_valid_next = 1'b1;
                rlast_next     = (mask_rest == '0);
                mask_next      = mask_rest;
                if (emit_bit == 3'(ALERT_SCAN))
                begin
                    kind_next = KIND_PORT_SCAN;
                end
                else if (emit_bit == 3'(ALERT_TRAFFIC))
                begin
                    kind_next = KIND_TRAFFIC;
                end
                else
                begin
                    kind_next  = KIND_SENSITIVE;
                    rport_next = sens_port_reg[2'(emit_bit - 3'd1)];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            pend_reg      <= pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            cmd_reg   <= cmd;
            key_reg   <= source_address;
            tcp_reg   <= is_tcp;
            udp_reg   <= is_udp;
            dport_reg <= destination_port;
            flen_reg  <= frame_length;
        end
        scan_idx_reg <= scan_idx_next;
        last_idx_reg <= last_idx_next;
        ent_reg      <= ent_next;
        rec_reg      <= rec_next;
        sens_reg     <= sens_next;
        pbase_reg    <= pbase_next;
        pidx_reg     <= pidx_next;
        found_reg    <= found_next;
        mask_reg     <= mask_next;
        kind_reg     <= kind_next;
        raddr_reg    <= raddr_next;
        rport_reg    <= rport_next;
        rtot_reg     <= rtot_next;
        rlast_reg    <= rlast_next;
    end

    assign busy             = (state_reg != ST_IDLE);
    assign result_valid     = res_valid_reg;
    assign alert_kind       = kind_reg;
    assign alert_address    = raddr_reg;
    assign alert_port       = rport_reg;
    assign packet_total     = rtot_reg.packets;
    assign byte_total       = rtot_reg.bytes;
    assign tcp_total        = rtot_reg.tcp;
    assign udp_total        = rtot_reg.udp;
    assign suspicious_total = rtot_reg.susp;
    assign last_result      = rlast_reg;

endmodule

// ===== rtl/pstad_checker.sv =====
// ----------------------------------------------------------------------------
// pstad_checker
// Port-level checks of the anomaly detector's command and result beats.
// ----------------------------------------------------------------------------
module pstad_checker
    import pstad_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        result_valid,
    input logic [2:0]  alert_kind,
    input logic [15:0] alert_port,
    input logic [31:0] packet_total,
    input logic [47:0] byte_total,
    input logic        last_result
);

    // an accepted command always occupies the block
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted command");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> alert_kind <= KIND_QUERY_MISS)
        else $error("alert_kind out of range");

    // single-result commands end with their one beat
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (alert_kind == KIND_TABLE_FULL
            || alert_kind == KIND_QUERY_HIT || alert_kind == KIND_QUERY_MISS)
        |-> last_result)
        else $error("single result not marked last");

    a_totals_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && alert_kind != KIND_QUERY_HIT
        |-> packet_total == '0 && byte_total == '0)
        else $error("counters shown on non-query result");

    a_port_only_sens: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && alert_kind != KIND_SENSITIVE |-> alert_port == '0)
        else $error("port shown on non-sensitive result");

endmodule

bind per_source_traffic_anomaly_detector_core pstad_checker u_pstad_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .alert_kind   (alert_kind),
    .alert_port   (alert_port),
    .packet_total (packet_total),
    .byte_total   (byte_total),
    .last_result  (last_result)
);

// ===== test/anomaly_scoreboard.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// anomaly_scoreboard
// Watches the command, configuration and result ports of the anomaly
// detector, predicts the alerts and query answers of every accepted command
// and compares each result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module anomaly_scoreboard
    import pstad_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  start,
    input  logic                  busy,
    input  logic                  cmd,
    input  logic [31:0]           source_address,
    input  logic                  is_tcp,
    input  logic                  is_udp,
    input  logic [15:0]           destination_port,
    input  logic [15:0]           frame_length,
    input  logic                  result_valid,
    input  logic [2:0]            alert_kind,
    input  logic [31:0]           alert_address,
    input  logic [15:0]           alert_port,
    input  logic [31:0]           packet_total,
    input  logic [47:0]           byte_total,
    input  logic [31:0]           tcp_total,
    input  logic [31:0]           udp_total,
    input  logic [31:0]           suspicious_total,
    input  logic                  last_result,
    output int                    pending,
    output int                    mismatches
);

    localparam int ENTRIES = DEF_TABLE_ENTRIES;
    localparam int PORTS   = DEF_MAX_TRACKED_PORTS;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] addr;
        logic [15:0] port;
        logic [31:0] pkts;
        logic [47:0] bytes;
        logic [31:0] tcp;
        logic [31:0] udp;
        logic [31:0] susp;
        logic        last;
    } alert_t;

    alert_t alerts_due[$];

    logic [4:0]  scan_thr;
    logic [15:0] sens_limit;
    logic [31:0] traffic_limit;
    logic [15:0] watch_port [NUM_SENS];

    logic        ent_valid [ENTRIES];
    logic [31:0] ent_addr  [ENTRIES];
    logic [31:0] ent_pkts  [ENTRIES];
    logic [47:0] ent_bytes [ENTRIES];
    logic [31:0] ent_tcp   [ENTRIES];
    logic [31:0] ent_udp   [ENTRIES];
    logic [31:0] ent_susp  [ENTRIES];
    logic [15:0] ent_sens  [ENTRIES][NUM_SENS];
    logic [15:0] ent_seen  [ENTRIES][PORTS];
    int          ent_seen_n[ENTRIES];
    int          fill;

    assign pending = alerts_due.size();

    function automatic logic [31:0] inc32(logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    task automatic report(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic push_alert(logic [2:0] kind, logic [31:0] addr, logic [15:0] port, int e);
        alert_t a;
        a = '0;
        a.kind = kind;
        a.addr = addr;
        a.port = port;
        if (e >= 0)
        begin
            a.pkts  = ent_pkts[e];
            a.bytes = ent_bytes[e];
            a.tcp   = ent_tcp[e];
            a.udp   = ent_udp[e];
            a.susp  = ent_susp[e];
        end
        alerts_due.insert(alerts_due.size(), a);
    endtask

    task automatic account(logic q, logic [31:0] addr, logic tcp, logic udp,
                           logic [15:0] dport, logic [15:0] flen);
        int          e;
        int          n;
        int          cnt;
        bit          found;
        logic [48:0] sum;
        e = -1;
        n = alerts_due.size();
        for (int i = 0; i < fill; i++)
            if (ent_valid[i] && ent_addr[i] == addr && e < 0)
                e = i;
        if (q == CMD_QUERY)
        begin
            push_alert(e >= 0 ? KIND_QUERY_HIT : KIND_QUERY_MISS, addr, '0, e);
        end
        else if (e < 0 && fill == ENTRIES)
        begin
            push_alert(KIND_TABLE_FULL, addr, '0, -1);
        end
        else
        begin
            if (e < 0)
            begin
                e = fill++;
                ent_valid[e] = 1'b1;
                ent_addr[e]  = addr;
                ent_pkts[e]  = '0;
                ent_bytes[e] = '0;
                ent_tcp[e]   = '0;
                ent_udp[e]   = '0;
                ent_susp[e]  = '0;
                ent_seen_n[e] = 0;
                for (int s = 0; s < NUM_SENS; s++)
                    ent_sens[e][s] = '0;
            end
            ent_pkts[e] = inc32(ent_pkts[e]);
            sum = {1'b0, ent_bytes[e]} + 49'(flen);
            ent_bytes[e] = sum[48] ? '1 : sum[47:0];
            if (tcp)
            begin
                ent_tcp[e] = inc32(ent_tcp[e]);
                cnt = ent_seen_n[e];
                found = 0;
                for (int j = 0; j < cnt; j++)
                    if (ent_seen[e][j] == dport)
                        found = 1;
                if (!found && cnt < PORTS)
                begin
                    ent_seen[e][cnt] = dport;
                    cnt++;
                end
                ent_seen_n[e] = cnt;
                for (int s = 0; s < NUM_SENS; s++)
                    if (dport == watch_port[s] && ent_sens[e][s] != '1)
                        ent_sens[e][s]++;
                if (cnt > scan_thr)
                begin
                    ent_susp[e] = inc32(ent_susp[e]);
                    push_alert(KIND_PORT_SCAN, addr, '0, -1);
                end
                for (int s = 0; s < NUM_SENS; s++)
                    if (ent_sens[e][s] > sens_limit)
                    begin
                        ent_susp[e] = inc32(ent_susp[e]);
                        push_alert(KIND_SENSITIVE, addr, watch_port[s], -1);
                    end
            end
            if (udp)
                ent_udp[e] = inc32(ent_udp[e]);
            if (ent_pkts[e] > traffic_limit)
                push_alert(KIND_TRAFFIC, addr, '0, -1);
        end
        if (alerts_due.size() > n)
            alerts_due[alerts_due.size() - 1].last = 1'b1;
    endtask

    task automatic check_beat();
        alert_t want;
        if (alerts_due.size() == 0)
        begin
            report($sformatf("unexpected result kind %0d addr %h", alert_kind, alert_address));
            return;
        end
        want = alerts_due.pop_front();
        if (alert_kind !== want.kind)
            report($sformatf("kind %0d, want %0d", alert_kind, want.kind));
        if (alert_address !== want.addr)
            report($sformatf("address %h, want %h", alert_address, want.addr));
        if (alert_port !== want.port)
            report($sformatf("port %0d, want %0d", alert_port, want.port));
        if (packet_total !== want.pkts)
            report($sformatf("packets %0d, want %0d", packet_total, want.pkts));
        if (byte_total !== want.bytes)
            report($sformatf("bytes %0d, want %0d", byte_total, want.bytes));
        if (tcp_total !== want.tcp)
            report($sformatf("tcp %0d, want %0d", tcp_total, want.tcp));
        if (udp_total !== want.udp)
            report($sformatf("udp %0d, want %0d", udp_total, want.udp));
        if (suspicious_total !== want.susp)
            report($sformatf("suspicious %0d, want %0d", suspicious_total, want.susp));
        if (last_result !== want.last)
            report($sformatf("last %b, want %b", last_result, want.last));
    endtask

    initial mismatches = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_thr      <= RST_SCAN_THR;
            sens_limit    <= RST_SENS_LIMIT;
            traffic_limit <= RST_TRAFFIC_LIM;
            watch_port[0] <= RST_SENS_PORT_A;
            watch_port[1] <= RST_SENS_PORT_B;
            watch_port[2] <= RST_SENS_PORT_C;
            watch_port[3] <= RST_SENS_PORT_D;
            fill = 0;
            for (int i = 0; i < ENTRIES; i++)
                ent_valid[i] = 1'b0;
            alerts_due.delete();
        end
        else
        begin
            if (result_valid)
                check_beat();
            if (start && !busy)
                account(cmd, source_address, is_tcp, is_udp, destination_port, frame_length);
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_SCAN_THR:    scan_thr      <= cfg_data[4:0];
                    CFG_SENS_LIMIT:  sens_limit    <= cfg_data[15:0];
                    CFG_TRAFFIC_LIM: traffic_limit <= cfg_data;
                    CFG_SENS_PORT_A: watch_port[0] <= cfg_data[15:0];
                    CFG_SENS_PORT_B: watch_port[1] <= cfg_data[15:0];
                    CFG_SENS_PORT_C: watch_port[2] <= cfg_data[15:0];
                    CFG_SENS_PORT_D: watch_port[3] <= cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the per-source traffic anomaly detector: directed corner
// commands and randomized bursts of packet and query beats over a small set
// of sources under several register settings.
// ----------------------------------------------------------------------------
module tb;
    import pstad_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 400;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  start;
    logic                  busy;
    logic                  cmd;
    logic [31:0]           source_address;
    logic                  is_tcp;
    logic                  is_udp;
    logic [15:0]           destination_port;
    logic [15:0]           frame_length;
    logic                  result_valid;
    logic [2:0]            alert_kind;
    logic [31:0]           alert_address;
    logic [15:0]           alert_port;
    logic [31:0]           packet_total;
    logic [47:0]           byte_total;
    logic [31:0]           tcp_total;
    logic [31:0]           udp_total;
    logic [31:0]           suspicious_total;
    logic                  last_result;
    int                    pending;
    int                    mismatches;
    int                    cycles;

    logic [31:0] src_pool  [6];
    logic [15:0] port_pool [6];

    per_source_traffic_anomaly_detector_core dut (.*);
    anomaly_scoreboard scoreboard (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send(logic c, logic [31:0] a, logic t, logic u,
                        logic [15:0] p, logic [15:0] l);
        cmd = c;
        source_address = a;
        is_tcp = t;
        is_udp = u;
        destination_port = p;
        frame_length = l;
        start = 1'b1;
        // busy only moves at rising edges, so a low value here means the
        // coming edge takes the beat
        while (busy)
            @(negedge clk);
        @(negedge clk);
    endtask

    task automatic gap(int n);
        start = 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic drain();
        start = 1'b0;
        @(negedge clk);
        while (pending != 0 || busy)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    task automatic random_regs();
        write_reg(CFG_SCAN_THR, $urandom_range(0, 3) == 0 ? $urandom_range(0, 31)
                                                          : $urandom_range(2, 12));
        write_reg(CFG_SENS_LIMIT, $urandom_range(0, 4) == 0 ? $urandom : $urandom_range(0, 4));
        write_reg(CFG_TRAFFIC_LIM, $urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 30));
        for (int s = 0; s < NUM_SENS; s++)
        begin
            port_pool[s] = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 40));
            write_reg(CFG_IDX_W'(CFG_SENS_PORT_A + s), {16'($urandom), port_pool[s]});
        end
    endtask

    task automatic random_beat();
        logic [31:0] a;
        logic [15:0] p;
        a = $urandom_range(0, 9) == 0 ? $urandom : src_pool[$urandom_range(0, 5)];
        case ($urandom_range(0, 9))
            0, 1, 2: p = port_pool[$urandom_range(0, 5)];
            3:       p = 16'($urandom);
            default: p = 16'($urandom_range(0, 40));
        endcase
        send($urandom_range(0, 6) == 0 ? CMD_QUERY : CMD_PACKET, a,
             $urandom_range(0, 4) != 0, $urandom_range(0, 2) == 0, p, 16'($urandom));
    endtask

    initial
    begin
        int left;
        bit held;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        start = 1'b0;
        cmd = CMD_PACKET;
        source_address = '0;
        is_tcp = 1'b0;
        is_udp = 1'b0;
        destination_port = '0;
        frame_length = '0;
        held = 1'b0;
        for (int i = 0; i < 6; i++)
        begin
            src_pool[i] = $urandom;
            port_pool[i] = 16'($urandom_range(0, 40));
        end
        src_pool[0] = '0;
        src_pool[1] = '1;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset register values
        send(CMD_QUERY,  32'h0, 1'b0, 1'b0, 16'h0, 16'h0);
        send(CMD_PACKET, 32'h0, 1'b1, 1'b0, 16'd22, 16'h0);
        send(CMD_PACKET, '1, 1'b0, 1'b1, '1, '1);
        send(CMD_PACKET, '1, 1'b1, 1'b1, '1, '1);
        send(CMD_PACKET, '1, 1'b0, 1'b0, 16'h0, 16'h1);
        send(CMD_QUERY,  '1, 1'b0, 1'b0, 16'h0, 16'h0);
        send(CMD_QUERY,  32'h0, 1'b1, 1'b1, '1, '1);
        drain();

        // every alert at once, all watched ports equal, out-of-range index
        write_reg(CFG_SCAN_THR, 32'h0);
        write_reg(CFG_SENS_LIMIT, 32'h0);
        write_reg(CFG_TRAFFIC_LIM, 32'h0);
        write_reg(CFG_SENS_PORT_A, 32'hFFFF_01BD);
        write_reg(CFG_SENS_PORT_B, 32'd445);
        write_reg(CFG_SENS_PORT_C, 32'd445);
        write_reg(CFG_SENS_PORT_D, 32'd445);
        write_reg(3'd7, '1);
        send(CMD_PACKET, 32'h0A000001, 1'b1, 1'b1, 16'd445, 16'd1500);
        send(CMD_PACKET, 32'h0A000001, 1'b0, 1'b0, 16'd445, 16'd64);
        send(CMD_QUERY,  32'h0A000001, 1'b0, 1'b0, 16'h0, 16'h0);
        drain();

        // upper extremes, then fill one source's port store past its capacity
        write_reg(CFG_SCAN_THR, 32'd31);
        write_reg(CFG_SENS_LIMIT, 32'd65534);
        write_reg(CFG_TRAFFIC_LIM, 32'hFFFF_FFFE);
        write_reg(CFG_SENS_PORT_A, 32'h0);
        write_reg(CFG_SENS_PORT_B, 32'hFFFF);
        write_reg(CFG_SENS_PORT_C, 32'h1);
        write_reg(CFG_SENS_PORT_D, 32'h2);
        for (int i = 0; i < 36; i++)
        begin
            send(CMD_PACKET, 32'hC0000001, 1'b1, 1'b0, 16'(i * 7), 16'($urandom));
            if ($urandom_range(0, 3) == 0)
                gap($urandom_range(1, 4));
        end
        send(CMD_QUERY, 32'hC0000001, 1'b0, 1'b0, 16'h0, 16'h0);
        drain();

        // randomized bursts under several register settings
        for (int ph = 0; ph < 4; ph++)
        begin
            random_regs();
            left = 28;
            while (left > 0)
            begin
                for (int b = $urandom_range(1, 8); b > 0 && left > 0; b--)
                begin
                    random_beat();
                    left--;
                end
                if (ph == 1 && left <= 14 && !held)
                begin
                    // hold off until every outstanding beat has come back
                    held = 1'b1;
                    start = 1'b0;
                    while (pending != 0 || busy)
                        @(negedge clk);
                end
                else if ($urandom_range(0, 2) != 0)
                begin
                    gap($urandom_range(1, 6));
                end
            end
            drain();
        end

        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/pstad_pkg.sv
rtl/per_source_traffic_anomaly_detector_core.sv
rtl/pstad_checker.sv
test/anomaly_scoreboard.sv
test/tb.sv
